### hw/rtl/lis_pkg.sv
package lis_pkg;

   localparam int MAX_ELEMENTS = 64;
   localparam int IDX_W        = $clog2(MAX_ELEMENTS);
   localparam int NUM_W        = $clog2(MAX_ELEMENTS + 1);
   localparam int VAL_W        = 32;
   localparam int LEN_W        = 7;
   localparam int CNT_W        = 31;
   localparam int KEY_W        = VAL_W + IDX_W;

   localparam logic [CNT_W-1:0] COUNT_CAP = CNT_W'(2000000001);

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_LEN_FETCH,
      ST_LEN_WAIT,
      ST_LEN_SCAN,
      ST_LEN_WRITE,
      ST_RANK,
      ST_CAND_START,
      ST_CAND_SCAN,
      ST_CAND_DECIDE,
      ST_FINISH
   } lis_state_type;

   typedef struct packed {
      logic [IDX_W-1:0] rd_addr;
      logic             val_we;
      logic             lc_we;
      logic [IDX_W-1:0] wr_addr;
      logic [VAL_W-1:0] val_wdata;
      logic [LEN_W-1:0] len_wdata;
      logic [CNT_W-1:0] cnt_wdata;
   } lis_mem_req_type;

   typedef struct packed {
      logic [VAL_W-1:0] val;
      logic [LEN_W-1:0] len;
      logic [CNT_W-1:0] cnt;
   } lis_mem_rsp_type;

   // Order key: biased value, then position.
   function automatic logic [KEY_W-1:0] order_key(input logic [VAL_W-1:0] v,
                                                  input logic [IDX_W-1:0] idx);
      order_key = {~v[VAL_W-1], v[VAL_W-2:0], idx};
   endfunction

   function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                input logic [CNT_W-1:0] b);
      logic [CNT_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      sat_add = (s > {1'b0, COUNT_CAP}) ? COUNT_CAP : s[CNT_W-1:0];
   endfunction

endpackage

### hw/rtl/lis_if.sv
interface lis_req_if import lis_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [VAL_W-1:0] value;
   logic             is_last;
   modport source (output valid, value, is_last, input ready);
   modport sink (input valid, value, is_last, output ready);
endinterface

interface lis_rsp_if import lis_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [VAL_W-1:0] element;
   logic             end_of_run;
   logic             found;
   logic [LEN_W-1:0] run_length;
   modport source (output valid, element, end_of_run, found, run_length, input ready);
   modport sink (input valid, element, end_of_run, found, run_length, output ready);
endinterface

interface lis_csr_if import lis_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [CNT_W-1:0] data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

### hw/rtl/lis_store.sv
module lis_store import lis_pkg::*; (
   input  logic            clock,
   input  lis_mem_req_type mem_req,
   output lis_mem_rsp_type mem_rsp
);

   logic [VAL_W-1:0]       val_mem [MAX_ELEMENTS];
   logic [LEN_W+CNT_W-1:0] lc_mem  [MAX_ELEMENTS];
   logic [VAL_W-1:0]       val_rd_ff;
   logic [LEN_W+CNT_W-1:0] lc_rd_ff;

   always_ff @(posedge clock) begin
      if (mem_req.val_we) begin
         val_mem[mem_req.wr_addr] <= mem_req.val_wdata;
      end
      if (mem_req.lc_we) begin
         lc_mem[mem_req.wr_addr] <= {mem_req.len_wdata, mem_req.cnt_wdata};
      end
      val_rd_ff <= val_mem[mem_req.rd_addr];
      lc_rd_ff  <= lc_mem[mem_req.rd_addr];
   end

   assign mem_rsp.val = val_rd_ff;
   assign mem_rsp.len = lc_rd_ff[LEN_W+CNT_W-1:CNT_W];
   assign mem_rsp.cnt = lc_rd_ff[CNT_W-1:0];

endmodule

### hw/rtl/lis_core.sv
module lis_core import lis_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic [CNT_W-1:0] rank,
   lis_req_if.sink          req,
   lis_rsp_if.source        rsp,
   output lis_mem_req_type  mem_req,
   input  lis_mem_rsp_type  mem_rsp
);

   lis_state_type    state_ff, state_in;
   logic [NUM_W-1:0] elem_cnt_ff, elem_cnt_in;
   logic [NUM_W-1:0] n_ff, n_in;
   logic [IDX_W-1:0] i_ff, i_in;
   logic [NUM_W-1:0] scan_j_ff, scan_j_in;
   logic             rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0] rd_idx_ff;
   logic [VAL_W-1:0] vi_ff, vi_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [LEN_W-1:0] best_len_ff, best_len_in;
   logic [CNT_W-1:0] total_ff, total_in;
   logic [CNT_W-1:0] skip_ff, skip_in;
   logic [LEN_W-1:0] need_ff, need_in;
   logic             has_node_ff, has_node_in;
   logic [IDX_W-1:0] node_ff, node_in;
   logic [VAL_W-1:0] vnode_ff, vnode_in;
   logic             has_after_ff, has_after_in;
   logic [KEY_W-1:0] after_key_ff, after_key_in;
   logic             bvld_ff, bvld_in;
   logic [KEY_W-1:0] bkey_ff, bkey_in;
   logic [CNT_W-1:0] bcnt_ff, bcnt_in;
   logic             pend_vld_ff, pend_vld_in;
   logic [VAL_W-1:0] pend_val_ff, pend_val_in;
   logic             out_vld_ff, out_vld_in;
   logic [VAL_W-1:0] out_elem_ff, out_elem_in;
   logic             out_end_ff, out_end_in;
   logic             out_found_ff, out_found_in;
   logic [LEN_W-1:0] out_len_ff, out_len_in;

   logic             accept, free, issue, scan_done, push, stall;
   logic [CNT_W-1:0] add_a, add_b, add_sum, cnt_w, skip_v;
   logic [LEN_W-1:0] cand_len;
   logic [KEY_W-1:0] key_j;
   logic [VAL_W-1:0] bval;
   logic             cand_ok;

   assign accept    = req.valid && req.ready;
   assign free      = !out_vld_ff || rsp.ready;
   assign issue     = (state_ff == ST_LEN_SCAN || state_ff == ST_CAND_SCAN) && (scan_j_ff < n_ff);
   assign scan_done = !issue && !rd_vld_ff;
   assign cand_len  = mem_rsp.len + LEN_W'(1);
   assign key_j     = order_key(mem_rsp.val, rd_idx_ff);
   assign bval      = {~bkey_ff[KEY_W-1], bkey_ff[KEY_W-2:IDX_W]};
   assign cnt_w     = (len_ff == LEN_W'(1)) ? CNT_W'(1) : cnt_ff;
   assign skip_v    = (rank == '0) ? '0 : rank - CNT_W'(1);
   assign stall     = pend_vld_ff && !free;
   assign cand_ok   = (!has_node_ff || (order_key(vnode_ff, '0) < order_key(mem_rsp.val, '0)))
                      && (mem_rsp.len == need_ff)
                      && (!has_after_ff || (after_key_ff < key_j));

   // shared saturating adder
   always_comb begin
      if (state_ff == ST_LEN_SCAN) begin
         add_a = cnt_ff;
         add_b = mem_rsp.cnt;
      end else begin
         add_a = total_ff;
         add_b = cnt_w;
      end
      add_sum = sat_add(add_a, add_b);
   end

   assign req.ready = (state_ff == ST_LOAD);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD:        if (accept && req.is_last) state_in = ST_LEN_FETCH;
         ST_LEN_FETCH:   state_in = ST_LEN_WAIT;
         ST_LEN_WAIT:    state_in = ST_LEN_SCAN;
         ST_LEN_SCAN:    if (scan_done) state_in = ST_LEN_WRITE;
         ST_LEN_WRITE:   state_in = (i_ff == '0) ? ST_RANK : ST_LEN_FETCH;
         ST_RANK:        state_in = (skip_v >= total_ff) ? ST_FINISH : ST_CAND_START;
         ST_CAND_START:  state_in = ST_CAND_SCAN;
         ST_CAND_SCAN:   if (scan_done) state_in = ST_CAND_DECIDE;
         ST_CAND_DECIDE: begin
            if (!bvld_ff) begin
               state_in = ST_FINISH;
            end else if (bcnt_ff > skip_ff) begin
               if (!stall) begin
                  state_in = (need_ff == LEN_W'(1)) ? ST_FINISH : ST_CAND_START;
               end
            end else begin
               state_in = ST_CAND_START;
            end
         end
         ST_FINISH:      if (free) state_in = ST_LOAD;
         default:        state_in = ST_LOAD;
      endcase
   end

   // datapath and outputs
   always_comb begin
      elem_cnt_in  = elem_cnt_ff;
      n_in         = n_ff;
      i_in         = i_ff;
      scan_j_in    = scan_j_ff;
      vi_in        = vi_ff;
      len_in       = len_ff;
      cnt_in       = cnt_ff;
      best_len_in  = best_len_ff;
      total_in     = total_ff;
      skip_in      = skip_ff;
      need_in      = need_ff;
      has_node_in  = has_node_ff;
      node_in      = node_ff;
      vnode_in     = vnode_ff;
      has_after_in = has_after_ff;
      after_key_in = after_key_ff;
      bvld_in      = bvld_ff;
      bkey_in      = bkey_ff;
      bcnt_in      = bcnt_ff;
      pend_vld_in  = pend_vld_ff;
      pend_val_in  = pend_val_ff;
      push         = 1'b0;
      out_elem_in  = pend_val_ff;
      out_end_in   = 1'b0;
      out_found_in = 1'b1;
      out_len_in   = best_len_ff;
      rd_vld_in    = issue;
      if (issue) scan_j_in = scan_j_ff + NUM_W'(1);

      mem_req.rd_addr   = (state_ff == ST_LEN_FETCH) ? i_ff : scan_j_ff[IDX_W-1:0];
      mem_req.val_we    = 1'b0;
      mem_req.lc_we     = 1'b0;
      mem_req.wr_addr   = (state_ff == ST_LOAD) ? elem_cnt_ff[IDX_W-1:0] : i_ff;
      mem_req.val_wdata = req.value;
      mem_req.len_wdata = len_ff;
      mem_req.cnt_wdata = cnt_w;

      case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               if (elem_cnt_ff < NUM_W'(MAX_ELEMENTS)) begin
                  mem_req.val_we = 1'b1;
                  n_in           = elem_cnt_ff + NUM_W'(1);
               end else begin
                  n_in = elem_cnt_ff;
               end
               elem_cnt_in = n_in;
               if (req.is_last) begin
                  elem_cnt_in = '0;
                  i_in        = IDX_W'(n_in - NUM_W'(1));
                  best_len_in = '0;
                  total_in    = '0;
               end
            end
         end
         ST_LEN_WAIT: begin
            vi_in     = mem_rsp.val;
            len_in    = LEN_W'(1);
            cnt_in    = '0;
            scan_j_in = NUM_W'(i_ff) + NUM_W'(1);
         end
         ST_LEN_SCAN: begin
            if (rd_vld_ff && (order_key(vi_ff, '0) < order_key(mem_rsp.val, '0))) begin
               if (cand_len > len_ff) begin
                  len_in = cand_len;
                  cnt_in = mem_rsp.cnt;
               end else if (cand_len == len_ff) begin
                  cnt_in = add_sum;
               end
            end
         end
         ST_LEN_WRITE: begin
            mem_req.lc_we = 1'b1;
            if (len_ff > best_len_ff) begin
               best_len_in = len_ff;
               total_in    = cnt_w;
            end else if (len_ff == best_len_ff) begin
               total_in = add_sum;
            end
            i_in = i_ff - IDX_W'(1);
         end
         ST_RANK: begin
            skip_in      = skip_v;
            need_in      = best_len_ff;
            has_node_in  = 1'b0;
            has_after_in = 1'b0;
            pend_vld_in  = 1'b0;
         end
         ST_CAND_START: begin
            scan_j_in = has_node_ff ? NUM_W'(node_ff) + NUM_W'(1) : '0;
            bvld_in   = 1'b0;
         end
         ST_CAND_SCAN: begin
            if (rd_vld_ff && cand_ok && (!bvld_ff || key_j < bkey_ff)) begin
               bvld_in = 1'b1;
               bkey_in = key_j;
               bcnt_in = mem_rsp.cnt;
            end
         end
         ST_CAND_DECIDE: begin
            if (bvld_ff) begin
               if (bcnt_ff > skip_ff) begin
                  if (!stall) begin
                     push         = pend_vld_ff;
                     pend_vld_in  = 1'b1;
                     pend_val_in  = bval;
                     has_node_in  = 1'b1;
                     node_in      = bkey_ff[IDX_W-1:0];
                     vnode_in     = bval;
                     has_after_in = 1'b0;
                     need_in      = need_ff - LEN_W'(1);
                  end
               end else begin
                  skip_in      = skip_ff - bcnt_ff;
                  after_key_in = bkey_ff;
                  has_after_in = 1'b1;
               end
            end
         end
         ST_FINISH: begin
            if (free) begin
               push         = 1'b1;
               out_elem_in  = pend_vld_ff ? pend_val_ff : '0;
               out_end_in   = 1'b1;
               out_found_in = pend_vld_ff;
            end
         end
         default: begin
         end
      endcase

      if (push) begin
         out_vld_in = 1'b1;
      end else begin
         out_vld_in = out_vld_ff && !rsp.ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_LOAD;
         elem_cnt_ff <= '0;
         rd_vld_ff   <= 1'b0;
         out_vld_ff  <= 1'b0;
         best_len_ff <= '0;
         total_ff    <= '0;
         n_ff        <= NUM_W'(1);
      end else begin
         state_ff    <= state_in;
         elem_cnt_ff <= elem_cnt_in;
         rd_vld_ff   <= rd_vld_in;
         out_vld_ff  <= out_vld_in;
         best_len_ff <= best_len_in;
         total_ff    <= total_in;
         n_ff        <= n_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff         <= i_in;
      scan_j_ff    <= scan_j_in;
      rd_idx_ff    <= scan_j_ff[IDX_W-1:0];
      vi_ff        <= vi_in;
      len_ff       <= len_in;
      cnt_ff       <= cnt_in;
      skip_ff      <= skip_in;
      need_ff      <= need_in;
      has_node_ff  <= has_node_in;
      node_ff      <= node_in;
      vnode_ff     <= vnode_in;
      has_after_ff <= has_after_in;
      after_key_ff <= after_key_in;
      bvld_ff      <= bvld_in;
      bkey_ff      <= bkey_in;
      bcnt_ff      <= bcnt_in;
      pend_vld_ff  <= pend_vld_in;
      pend_val_ff  <= pend_val_in;
      if (push) begin
         out_elem_ff  <= out_elem_in;
         out_end_ff   <= out_end_in;
         out_found_ff <= out_found_in;
         out_len_ff   <= out_len_in;
      end
   end

   assign rsp.valid      = out_vld_ff;
   assign rsp.element    = out_elem_ff;
   assign rsp.end_of_run = out_end_ff;
   assign rsp.found      = out_found_ff;
   assign rsp.run_length = out_len_ff;

`ifndef SYNTH
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      elem_cnt_ff <= NUM_W'(MAX_ELEMENTS))
      else $error("element count beyond store depth");
   a_n_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_LOAD) |-> (n_ff != '0))
      else $error("processing an empty sequence");
   a_total_nonzero: assert property (@(posedge clock) disable iff (reset)
      (best_len_ff != '0) |-> (total_ff != '0))
      else $error("longest length without a count");
   a_no_push_lost: assert property (@(posedge clock) disable iff (reset)
      push |-> free)
      else $error("result pushed over a waiting one");
`endif

endmodule

### hw/rtl/kth_longest_increasing_subsequence.sv
// Loads up to 64 signed values, one item per cycle, and on the item
// marked is_last reports the rank-th longest increasing subsequence in
// lexicographic order, one result per element, the last flagged end_of_run;
// a rank past the number of such subsequences gives one result with found
// cleared. Values beyond the 64th are dropped. All work runs through one
// memory read port and a single saturating adder, one entry per cycle:
// the length/count pass scans, for each held value, the values after it,
// and every candidate examined, whether taken or skipped past, costs one
// scan of the held values; no item is taken while a sequence is worked
// on. The rank register may be written at any time the block is idle.
module kth_longest_increasing_subsequence import lis_pkg::*; (
   input logic       clock,
   input logic       reset,
   lis_req_if.sink   req,
   lis_rsp_if.source rsp,
   lis_csr_if.sink   csr
);

   logic [CNT_W-1:0] rank_ff;
   lis_mem_req_type  mem_req;
   lis_mem_rsp_type  mem_rsp;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rank_ff <= CNT_W'(1);
      end else if (csr.valid && csr.ready) begin
         rank_ff <= csr.data;
      end
   end

   lis_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .mem_rsp (mem_rsp)
   );

   lis_core u_core (
      .clock   (clock),
      .reset   (reset),
      .rank    (rank_ff),
      .req     (req),
      .rsp     (rsp),
      .mem_req (mem_req),
      .mem_rsp (mem_rsp)
   );

endmodule

### bench/kth_longest_increasing_subsequence_tb.sv
module kth_longest_increasing_subsequence_tb;
   import lis_pkg::*;

   typedef struct packed {
      logic [VAL_W-1:0] element;
      logic             end_of_run;
      logic             found;
      logic [LEN_W-1:0] run_length;
   } lis_result_type;

   localparam int unsigned SAT_COUNT  = 2000000001;
   localparam int unsigned RANK_MAX   = 2000000000;
   localparam int          IDLE_LIMIT = 200000;
   localparam int          SETTLE     = 40;

   logic clock;
   logic reset;

   lis_req_if req_bus ();
   lis_rsp_if rsp_bus ();
   lis_csr_if csr_bus ();

   kth_longest_increasing_subsequence dut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus),
      .csr   (csr_bus)
   );

   lis_result_type   subseq_queue[$];
   logic [VAL_W-1:0] loaded_vals[$];
   logic [CNT_W-1:0] rank_reg;
   int               error_count;
   int               items_sent;
   int               results_seen;
   int               runs_done;
   int               idle_cycles;
   int               burst_left;
   bit               no_gaps;
   logic [15:0]      stall_pattern;
   int               stall_phase;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic int unsigned sat_sum(int unsigned a, int unsigned b);
      longint unsigned s;
      s = longint'(a) + longint'(b);
      return (s > SAT_COUNT) ? SAT_COUNT : int'(s);
   endfunction

   // Work out the chosen subsequence for the held values and the current rank.
   function automatic void predict_subsequence();
      int               n;
      int               best_len;
      int unsigned      total;
      int unsigned      skip;
      int               run_len[64];
      int unsigned      run_cnt[64];
      logic signed [31:0] v[64];
      int               need;
      int               k;
      int               node;
      bit               has_node;
      int               after;
      bit               has_after;
      int               c;
      int               len;
      int unsigned      cnt;
      lis_result_type   r;
      n = loaded_vals.size();
      best_len = 0;
      total = 0;
      k = 0;
      node = 0;
      has_node = 0;
      for (int i = 0; i < n; i++) v[i] = loaded_vals[i];
      for (int i = n - 1; i >= 0; i--) begin
         len = 1;
         cnt = 0;
         for (int j = i + 1; j < n; j++)
            if (v[i] < v[j] && run_len[j] + 1 > len) len = run_len[j] + 1;
         if (len == 1) cnt = 1;
         else
            for (int j = i + 1; j < n; j++)
               if (v[i] < v[j] && run_len[j] + 1 == len) cnt = sat_sum(cnt, run_cnt[j]);
         run_len[i] = len;
         run_cnt[i] = cnt;
         if (len > best_len) best_len = len;
      end
      for (int i = 0; i < n; i++)
         if (run_len[i] == best_len) total = sat_sum(total, run_cnt[i]);
      skip = (rank_reg == 0) ? 0 : rank_reg - 1;
      if (skip < total) begin
         for (need = best_len; need >= 1; need--) begin
            has_after = 0;
            after = 0;
            forever begin
               c = n;
               for (int j = has_node ? node + 1 : 0; j < n; j++) begin
                  if (has_node && !(v[node] < v[j])) continue;
                  if (run_len[j] != need) continue;
                  if (has_after && !(v[after] < v[j] || (v[after] == v[j] && after < j)))
                     continue;
                  if (c == n || v[j] < v[c] || (v[j] == v[c] && j < c)) c = j;
               end
               if (c == n || run_cnt[c] > skip) break;
               skip -= run_cnt[c];
               has_after = 1;
               after = c;
            end
            if (c == n) break;
            r.element    = v[c];
            r.end_of_run = (need == 1);
            r.found      = 1'b1;
            r.run_length = LEN_W'(best_len);
            subseq_queue.insert(subseq_queue.size(), r);
            k++;
            node = c;
            has_node = 1;
         end
         if (k > 0) subseq_queue[$].end_of_run = 1'b1;
      end
      if (k == 0) begin
         r.element    = '0;
         r.end_of_run = 1'b1;
         r.found      = 1'b0;
         r.run_length = LEN_W'(best_len);
         subseq_queue.insert(subseq_queue.size(), r);
      end
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch on %s: got %0h, expected %0h (result %0d)",
               what, got, want, results_seen);
      error_count++;
   endtask

   // Check each accepted result against the oldest expectation.
   always @(posedge clock) begin
      lis_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         results_seen++;
         if (subseq_queue.size() == 0) begin
            report_mismatch("unexpected result", rsp_bus.element, 32'h0);
         end else begin
            want = subseq_queue.pop_front();
            if (rsp_bus.element !== want.element)
               report_mismatch("element", rsp_bus.element, want.element);
            if (rsp_bus.end_of_run !== want.end_of_run)
               report_mismatch("end_of_run", 32'(rsp_bus.end_of_run), 32'(want.end_of_run));
            if (rsp_bus.found !== want.found)
               report_mismatch("found", 32'(rsp_bus.found), 32'(want.found));
            if (rsp_bus.run_length !== want.run_length)
               report_mismatch("run_length", 32'(rsp_bus.run_length), 32'(want.run_length));
         end
      end
   end

   // Receiver: stall on a rotating pattern, changed now and then.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_pattern <= 16'hffff;
         stall_phase   <= 0;
      end else begin
         rsp_bus.ready <= stall_pattern[0];
         stall_phase   <= stall_phase + 1;
         if (stall_phase % 97 == 96)
            stall_pattern <= ($urandom_range(0, 2) == 0) ? 16'hffff : 16'($urandom) | 16'h0101;
         else
            stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready))
         idle_cycles <= 0;
      else if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
         $display("Regression FAIL");
         $finish;
      end else idle_cycles <= idle_cycles + 1;
   end

   task automatic send_item(logic [VAL_W-1:0] value, bit last);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         if (!no_gaps) begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
      burst_left--;
      req_bus.valid   <= 1'b1;
      req_bus.value   <= value;
      req_bus.is_last <= last;
      do @(posedge clock); while (!req_bus.ready);
      items_sent++;
      if (loaded_vals.size() < MAX_ELEMENTS) loaded_vals.insert(loaded_vals.size(), value);
      if (last) begin
         predict_subsequence();
         loaded_vals.delete();
         runs_done++;
      end
   endtask

   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (subseq_queue.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_rank(logic [CNT_W-1:0] r);
      wait_idle();
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= r;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      rank_reg = r;
   endtask

   task automatic send_sequence(logic [VAL_W-1:0] vals[$]);
      foreach (vals[i]) send_item(vals[i], i == vals.size() - 1);
   endtask

   task automatic test_directed();
      send_sequence({32'h8000_0000});
      send_sequence({32'h7fff_ffff, 32'h8000_0000});
      send_sequence({32'h8000_0000, 32'hffff_ffff, 32'h0, 32'h7fff_ffff});
      // equal values: strictly increasing only
      send_sequence({32'd3, 32'd1, 32'd3, 32'd2, 32'd3});
      write_rank(CNT_W'(0));
      send_sequence({32'd5, 32'd4, 32'd6, 32'd7});
      write_rank(CNT_W'(3));
      send_sequence({32'd2, 32'd1, 32'd4, 32'd3});
      write_rank(CNT_W'(RANK_MAX));
      send_sequence({32'd9, 32'd8, 32'd7});
   endtask

   task automatic test_store_full();
      logic [VAL_W-1:0] vals[$];
      write_rank(CNT_W'(2));
      for (int i = 0; i < 70; i++) vals.insert(vals.size(), $urandom);
      send_sequence(vals);
   endtask

   // Descending pairs give 2**32 longest runs, past the count cap.
   task automatic test_saturated_count();
      logic [VAL_W-1:0] vals[$];
      for (int i = 0; i < 32; i++) begin
         vals.insert(vals.size(), 2 * i + 1);
         vals.insert(vals.size(), 2 * i);
      end
      write_rank(CNT_W'(RANK_MAX));
      send_sequence(vals);
      write_rank(CNT_W'(32'h7fff_ffff));
      send_sequence(vals);
      write_rank(CNT_W'(1));
      send_sequence(vals);
   endtask

   task automatic test_random();
      logic [VAL_W-1:0] vals[$];
      int               len;
      int               kind;
      while (items_sent < 460) begin
         no_gaps = ($urandom_range(0, 4) == 0);
         kind = $urandom_range(0, 9);
         if (kind < 6) write_rank(CNT_W'($urandom_range(1, 6)));
         else if (kind == 6) write_rank(CNT_W'(0));
         else if (kind == 7) write_rank(CNT_W'($urandom_range(1, RANK_MAX)));
         vals.delete();
         len = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 66) : $urandom_range(1, 12);
         kind = $urandom_range(0, 3);
         for (int i = 0; i < len; i++)
            vals.insert(vals.size(),
                        kind == 0 ? $urandom : $signed($urandom_range(0, 40)) - 20);
         send_sequence(vals);
      end
      no_gaps = 0;
   endtask

   initial begin
      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.value   = '0;
      req_bus.is_last = 1'b0;
      csr_bus.valid   = 1'b0;
      csr_bus.data    = '0;
      rank_reg        = CNT_W'(1);
      error_count     = 0;
      items_sent      = 0;
      results_seen    = 0;
      runs_done       = 0;
      idle_cycles     = 0;
      burst_left      = 0;
      no_gaps         = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_store_full();
      test_saturated_count();
      test_random();
      wait_idle();
      $display("sent %0d items over %0d sequences, checked %0d results",
               items_sent, runs_done, results_seen);
      if (error_count == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule
